// ===== src/kalman_trajectory_smoother_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory smoother
// Concurrent checks on one clock with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef KALMAN_TRAJECTORY_SMOOTHER_UNIT_ASSERT_SVH
`define KALMAN_TRAJECTORY_SMOOTHER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define KTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kts assertion failed");
// cond must never be true outside reset
`define KTS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("kts forbidden condition seen");
`else
`define KTS_ASSERT(label, clk, rst, prop)
`define KTS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Widths, constants, types and helpers shared by the trajectory smoother.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_W      = 32;
   localparam int PNOISE_W    = 16;
   localparam int MNOISE_W    = 24;
   localparam int LIMIT_W     = 31;
   localparam int AXES        = 3;

   // variance store: 2 integer bits
   localparam int VAR_W       = FRAC_BITS + 2;
   // gain in [0, 1.0]
   localparam int K_W         = FRAC_BITS + 1;
   localparam int DIVIDEND_W  = VAR_W + FRAC_BITS;
   localparam int DEN_W       = ((VAR_W > MNOISE_W) ? VAR_W : MNOISE_W) + 1;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
   localparam int MAG_W       = WORD_W;
   localparam int RES_W       = MAG_W + 1;
   localparam int PROD_W      = MAG_W + K_W;
   localparam int MUL_CNT_W   = $clog2(K_W);
   localparam int EXT_W       = WORD_W + 3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_X_RESTART_LIMIT   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_RESTART_LIMIT   = CSR_INDEX_W'(3);

   localparam int PNOISE_FULL = ((1 << FRAC_BITS) * 4 + 500) / 1000;
   localparam logic [PNOISE_W-1:0] PNOISE_RESET = PNOISE_W'(PNOISE_FULL);
   localparam logic [MNOISE_W-1:0] MNOISE_RESET = MNOISE_W'(1 << FRAC_BITS);
   localparam logic [LIMIT_W-1:0]  XLIMIT_RESET = LIMIT_W'(32 << FRAC_BITS);
   localparam logic [LIMIT_W-1:0]  YLIMIT_RESET = LIMIT_W'(24 << FRAC_BITS);

   localparam logic [VAR_W-1:0]  VAR_ONE    = VAR_W'(1) << FRAC_BITS;
   localparam logic [VAR_W-1:0]  VAR_MAX    = '1;
   localparam logic [K_W-1:0]    K_ONE      = K_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_DIFF,
      ST_MULTIPLY,
      ST_RESULT
   } kts_state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_ANGLE,
      AXIS_VAR
   } kts_axis_type;

   typedef struct packed {
      logic [PNOISE_W-1:0] process_noise;
      logic [MNOISE_W-1:0] measurement_noise;
      logic [LIMIT_W-1:0]  x_limit;
      logic [LIMIT_W-1:0]  y_limit;
   } kts_cfg_type;

   typedef struct packed {
      logic             start;
      logic [VAR_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } kts_div_req_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [K_W-1:0] quotient;
   } kts_div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mcand;
      logic [K_W-1:0]   mplier;
   } kts_mul_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RES_W-1:0] product;
   } kts_mul_rsp_type;

   // clamp a wide signed value to the 32-bit range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [EXT_W-1:0] v);
      logic [EXT_W-WORD_W:0] top_bits;
      top_bits = v[EXT_W-1:WORD_W-1];
      if (top_bits == '0 || top_bits == '1) begin
         return v[WORD_W-1:0];
      end else if (v[EXT_W-1]) begin
         return WORD_MIN;
      end else begin
         return WORD_MAX;
      end
   endfunction

endpackage

// ===== src/kts_channels.sv =====
// ----------------------------------------------------------------------------
// Trajectory smoother channels
// Valid/ready interfaces for motion items, corrections and register writes.
// ----------------------------------------------------------------------------
interface kts_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [kts_pkg::WORD_W-1:0] motion_x;
   logic signed [kts_pkg::WORD_W-1:0] motion_y;
   logic signed [kts_pkg::WORD_W-1:0] motion_angle;
   logic                              no_transform;

   modport source (output valid, motion_x, motion_y, motion_angle, no_transform,
                   input ready);
   modport sink (input valid, motion_x, motion_y, motion_angle, no_transform,
                 output ready);
endinterface

interface kts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [kts_pkg::WORD_W-1:0] correct_x;
   logic signed [kts_pkg::WORD_W-1:0] correct_y;
   logic signed [kts_pkg::WORD_W-1:0] correct_angle;
   logic                              restarted;

   modport source (output valid, correct_x, correct_y, correct_angle, restarted,
                   input ready);
   modport sink (input valid, correct_x, correct_y, correct_angle, restarted,
                 output ready);
endinterface

interface kts_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kts_pkg::CSR_INDEX_W-1:0]     index;
   logic [kts_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/kts_csr.sv =====
// ----------------------------------------------------------------------------
// kts_csr
// Register file for noise variances and restart limits.
// ----------------------------------------------------------------------------
module kts_csr (
   input  logic                 clock,
   input  logic                 reset,
   kts_csr_if.sink              csr_chan,
   output kts_pkg::kts_cfg_type cfg
);

   kts_pkg::kts_cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            kts_pkg::CSR_PROCESS_NOISE:
               cfg_in.process_noise = csr_chan.data[kts_pkg::PNOISE_W-1:0];
            kts_pkg::CSR_MEASUREMENT_NOISE:
               cfg_in.measurement_noise = csr_chan.data[kts_pkg::MNOISE_W-1:0];
            kts_pkg::CSR_X_RESTART_LIMIT:
               cfg_in.x_limit = csr_chan.data[kts_pkg::LIMIT_W-1:0];
            kts_pkg::CSR_Y_RESTART_LIMIT:
               cfg_in.y_limit = csr_chan.data[kts_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.process_noise     <= kts_pkg::PNOISE_RESET;
         cfg_ff.measurement_noise <= kts_pkg::MNOISE_RESET;
         cfg_ff.x_limit           <= kts_pkg::XLIMIT_RESET;
         cfg_ff.y_limit           <= kts_pkg::YLIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/kts_divider.sv =====
// ----------------------------------------------------------------------------
// kts_divider
// Bit-serial restoring divider: gain = (pp << FRAC_BITS) / (pp + R).
// ----------------------------------------------------------------------------
module kts_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  kts_pkg::kts_div_req_type div_req,
   output kts_pkg::kts_div_rsp_type div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [kts_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [kts_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [kts_pkg::DEN_W-1:0]         dsr_ff, dsr_in;
   logic [kts_pkg::DIVIDEND_W-1:0]    dvd_ff, dvd_in;
   logic [kts_pkg::K_W-1:0]           quot_ff, quot_in;
   logic [kts_pkg::DEN_W:0]           partial;
   logic [kts_pkg::DEN_W:0]           trial;

   assign partial = {rem_ff, dvd_ff[kts_pkg::DIVIDEND_W-1]};
   assign trial   = partial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         dvd_in  = {div_req.dividend, {kts_pkg::FRAC_BITS{1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[kts_pkg::DIVIDEND_W-2:0], 1'b0};
         // keep the trial difference when it does not go negative
         if (!trial[kts_pkg::DEN_W]) begin
            rem_in  = trial[kts_pkg::DEN_W-1:0];
            quot_in = {quot_ff[kts_pkg::K_W-2:0], 1'b1};
         end else begin
            rem_in  = partial[kts_pkg::DEN_W-1:0];
            quot_in = {quot_ff[kts_pkg::K_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == kts_pkg::DIV_CNT_W'(kts_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   // a zero denominator gives zero gain
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = (dsr_ff == '0) ? '0 : quot_ff;

endmodule

// ===== src/kts_multiplier.sv =====
// ----------------------------------------------------------------------------
// kts_multiplier
// Bit-serial shift-add multiplier with round-half-up scaling by FRAC_BITS.
// ----------------------------------------------------------------------------
module kts_multiplier (
   input  logic                     clock,
   input  logic                     reset,
   input  kts_pkg::kts_mul_req_type mul_req,
   output kts_pkg::kts_mul_rsp_type mul_rsp
);

   logic                          busy_ff, busy_in;
   logic                          rnd_ff, rnd_in;
   logic                          done_ff, done_in;
   logic [kts_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [kts_pkg::MAG_W-1:0]     mcand_ff, mcand_in;
   logic [kts_pkg::K_W-1:0]       mplier_ff, mplier_in;
   logic [kts_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [kts_pkg::PROD_W-1:0]    addend;

   assign addend = mplier_ff[kts_pkg::K_W-1] ? kts_pkg::PROD_W'(mcand_ff) : '0;

   always_comb begin
      busy_in   = busy_ff;
      rnd_in    = rnd_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         rnd_in    = 1'b0;
         cnt_in    = '0;
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
         acc_in    = '0;
      end else if (busy_ff && rnd_ff) begin
         acc_in  = acc_ff + kts_pkg::ROUND_HALF;
         busy_in = 1'b0;
         rnd_in  = 1'b0;
         done_in = 1'b1;
      end else if (busy_ff) begin
         // multiplier bits go MSB first
         acc_in    = {acc_ff[kts_pkg::PROD_W-2:0], 1'b0} + addend;
         mplier_in = {mplier_ff[kts_pkg::K_W-2:0], 1'b0};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == kts_pkg::MUL_CNT_W'(kts_pkg::K_W - 1)) begin
            rnd_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff[kts_pkg::FRAC_BITS +: kts_pkg::RES_W];

endmodule

// ===== src/kalman_trajectory_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// kalman_trajectory_smoother_unit
// Scalar Kalman smoothing of a camera trajectory, one frame motion per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_chan  in         valid/ready        motion_x, motion_y, motion_angle,
//                                          no_transform
//  rsp_chan  out        valid/ready        correct_x, correct_y, correct_angle,
//                                          restarted
//  csr_chan  in         valid/ready        index, data (always ready)
//
//  A filtered frame's result comes from the gain divider (setup and handoff
//  included), then four multiplier passes (three axes and the variance), and
//  is then loaded into the output register. A restarting frame skips the
//  divider and multiplier and goes straight to the output register. req_chan
//  is ready again the cycle after the result loads; a stalled rsp_chan holds
//  the next result only. Synchronous reset clears the filter state.
// ----------------------------------------------------------------------------
`include "kalman_trajectory_smoother_unit_assert.svh"

module kalman_trajectory_smoother_unit (
   input  logic      clock,
   input  logic      reset,
   kts_req_if.sink   req_chan,
   kts_rsp_if.source rsp_chan,
   kts_csr_if.sink   csr_chan
);

   kts_pkg::kts_cfg_type     cfg;
   kts_pkg::kts_div_req_type div_req;
   kts_pkg::kts_div_rsp_type div_rsp;
   kts_pkg::kts_mul_req_type mul_req;
   kts_pkg::kts_mul_rsp_type mul_rsp;

   kts_pkg::kts_state_type state_ff, state_in;
   kts_pkg::kts_axis_type  axis_ff, axis_in;

   logic signed [kts_pkg::WORD_W-1:0] traj_ff [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] traj_in [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] est_ff  [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] est_in  [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] last_ff [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] last_in [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] corr_ff [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] corr_in [kts_pkg::AXES];

   logic [kts_pkg::VAR_W-1:0] var_ff, var_in;
   logic [kts_pkg::VAR_W-1:0] pp_ff, pp_in;
   logic [kts_pkg::K_W-1:0]   k_ff, k_in;
   logic                      first_ff, first_in;
   logic                      restart_ff, restart_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_restarted_ff, rsp_restarted_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                              accept;
   logic signed [kts_pkg::WORD_W-1:0] motion [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] traj_sum [kts_pkg::AXES];
   logic signed [kts_pkg::WORD_W-1:0] corr_calc [kts_pkg::AXES];
   logic [kts_pkg::WORD_W-1:0]        abs_x, abs_y;
   logic                              over_x, over_y, restart_now;
   logic [kts_pkg::VAR_W:0]           pp_sum;
   logic [kts_pkg::VAR_W-1:0]         pp_calc;
   logic signed [kts_pkg::WORD_W-1:0] traj_sel, est_sel, est_upd;
   logic signed [kts_pkg::WORD_W:0]   diff_pos, diff_neg;
   logic signed [kts_pkg::EXT_W-1:0]  est_ext, delta_ext, est_sum;

   kts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   kts_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   kts_multiplier u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_chan.ready = (state_ff == kts_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // frame motion: fall back to the last good motion when none was found
   assign motion[0] = req_chan.no_transform ? last_ff[0] : req_chan.motion_x;
   assign motion[1] = req_chan.no_transform ? last_ff[1] : req_chan.motion_y;
   assign motion[2] = req_chan.no_transform ? last_ff[2] : req_chan.motion_angle;

   assign abs_x  = motion[0][kts_pkg::WORD_W-1] ? (~motion[0] + 1'b1) : motion[0];
   assign abs_y  = motion[1][kts_pkg::WORD_W-1] ? (~motion[1] + 1'b1) : motion[1];
   assign over_x = abs_x > kts_pkg::WORD_W'(cfg.x_limit);
   assign over_y = abs_y > kts_pkg::WORD_W'(cfg.y_limit);
   assign restart_now = first_ff || req_chan.no_transform || over_x || over_y;

   assign pp_sum  = (kts_pkg::VAR_W+1)'(var_ff) + (kts_pkg::VAR_W+1)'(cfg.process_noise);
   assign pp_calc = pp_sum[kts_pkg::VAR_W] ? kts_pkg::VAR_MAX : pp_sum[kts_pkg::VAR_W-1:0];

   always_comb begin
      for (int i = 0; i < kts_pkg::AXES; i++) begin
         traj_sum[i]  = kts_pkg::sat_word(kts_pkg::EXT_W'(traj_ff[i])
                                          + kts_pkg::EXT_W'(motion[i]));
         corr_calc[i] = kts_pkg::sat_word(kts_pkg::EXT_W'(est_ff[i])
                                          - kts_pkg::EXT_W'(traj_ff[i]));
      end
   end

   always_comb begin
      case (axis_ff)
         kts_pkg::AXIS_X: begin
            traj_sel = traj_ff[0];
            est_sel  = est_ff[0];
         end
         kts_pkg::AXIS_Y: begin
            traj_sel = traj_ff[1];
            est_sel  = est_ff[1];
         end
         kts_pkg::AXIS_ANGLE: begin
            traj_sel = traj_ff[2];
            est_sel  = est_ff[2];
         end
         default: begin
            traj_sel = '0;
            est_sel  = '0;
         end
      endcase
   end

   assign diff_pos  = (kts_pkg::WORD_W+1)'(traj_sel) - (kts_pkg::WORD_W+1)'(est_sel);
   assign diff_neg  = (kts_pkg::WORD_W+1)'(est_sel) - (kts_pkg::WORD_W+1)'(traj_sel);
   assign est_ext   = kts_pkg::EXT_W'(est_sel);
   assign delta_ext = kts_pkg::EXT_W'(mul_rsp.product);
   assign est_sum   = neg_ff ? (est_ext - delta_ext) : (est_ext + delta_ext);
   assign est_upd   = kts_pkg::sat_word(est_sum);

   always_comb begin
      state_in         = state_ff;
      axis_in          = axis_ff;
      traj_in          = traj_ff;
      est_in           = est_ff;
      last_in          = last_ff;
      corr_in          = corr_ff;
      var_in           = var_ff;
      pp_in            = pp_ff;
      k_in             = k_ff;
      first_in         = first_ff;
      restart_in       = restart_ff;
      neg_in           = neg_ff;
      rsp_restarted_in = rsp_restarted_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      div_req          = '0;
      mul_req          = '0;

      case (state_ff)
         kts_pkg::ST_IDLE: begin
            if (accept) begin
               first_in   = 1'b0;
               restart_in = restart_now;
               pp_in      = pp_calc;
               if (!req_chan.no_transform) begin
                  last_in = motion;
               end
               if (restart_now) begin
                  for (int i = 0; i < kts_pkg::AXES; i++) begin
                     traj_in[i] = '0;
                     est_in[i]  = '0;
                  end
                  var_in   = kts_pkg::VAR_ONE;
                  state_in = kts_pkg::ST_RESULT;
               end else begin
                  traj_in  = traj_sum;
                  state_in = kts_pkg::ST_PREP;
               end
            end
         end
         kts_pkg::ST_PREP: begin
            div_req.start    = 1'b1;
            div_req.dividend = pp_ff;
            div_req.divisor  = kts_pkg::DEN_W'(pp_ff)
                               + kts_pkg::DEN_W'(cfg.measurement_noise);
            state_in         = kts_pkg::ST_DIVIDE;
         end
         kts_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               k_in     = div_rsp.quotient;
               axis_in  = kts_pkg::AXIS_X;
               state_in = kts_pkg::ST_DIFF;
            end
         end
         kts_pkg::ST_DIFF: begin
            mul_req.start = 1'b1;
            if (axis_ff == kts_pkg::AXIS_VAR) begin
               mul_req.mcand  = kts_pkg::MAG_W'(pp_ff);
               mul_req.mplier = kts_pkg::K_ONE - k_ff;
               neg_in         = 1'b0;
            end else begin
               // work on the magnitude of trajectory minus estimate
               neg_in         = diff_pos[kts_pkg::WORD_W];
               mul_req.mcand  = diff_pos[kts_pkg::WORD_W] ? diff_neg[kts_pkg::WORD_W-1:0]
                                                          : diff_pos[kts_pkg::WORD_W-1:0];
               mul_req.mplier = k_ff;
            end
            state_in = kts_pkg::ST_MULTIPLY;
         end
         kts_pkg::ST_MULTIPLY: begin
            if (mul_rsp.done) begin
               case (axis_ff)
                  kts_pkg::AXIS_X: begin
                     est_in[0] = est_upd;
                     axis_in   = kts_pkg::AXIS_Y;
                     state_in  = kts_pkg::ST_DIFF;
                  end
                  kts_pkg::AXIS_Y: begin
                     est_in[1] = est_upd;
                     axis_in   = kts_pkg::AXIS_ANGLE;
                     state_in  = kts_pkg::ST_DIFF;
                  end
                  kts_pkg::AXIS_ANGLE: begin
                     est_in[2] = est_upd;
                     axis_in   = kts_pkg::AXIS_VAR;
                     state_in  = kts_pkg::ST_DIFF;
                  end
                  default: begin
                     if (mul_rsp.product > kts_pkg::RES_W'(kts_pkg::VAR_MAX)) begin
                        var_in = kts_pkg::VAR_MAX;
                     end else begin
                        var_in = mul_rsp.product[kts_pkg::VAR_W-1:0];
                     end
                     state_in = kts_pkg::ST_RESULT;
                  end
               endcase
            end
         end
         kts_pkg::ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               corr_in          = corr_calc;
               rsp_restarted_in = restart_ff;
               rsp_valid_in     = 1'b1;
               state_in         = kts_pkg::ST_IDLE;
            end
         end
         default: state_in = kts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kts_pkg::ST_IDLE;
         axis_ff      <= kts_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         var_ff       <= kts_pkg::VAR_ONE;
         for (int i = 0; i < kts_pkg::AXES; i++) begin
            traj_ff[i] <= '0;
            est_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         var_ff       <= var_in;
         traj_ff      <= traj_in;
         est_ff       <= est_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff            <= pp_in;
      k_ff             <= k_in;
      restart_ff       <= restart_in;
      neg_ff           <= neg_in;
      corr_ff          <= corr_in;
      rsp_restarted_ff <= rsp_restarted_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.correct_x     = corr_ff[0];
   assign rsp_chan.correct_y     = corr_ff[1];
   assign rsp_chan.correct_angle = corr_ff[2];
   assign rsp_chan.restarted     = rsp_restarted_ff;

   `KTS_ASSERT_NEVER(a_units_exclusive, clock, reset, div_rsp.busy && mul_rsp.busy)
   `KTS_ASSERT(a_gain_bounded, clock, reset,
      (state_ff == kts_pkg::ST_DIFF) |-> (k_ff <= kts_pkg::K_ONE))
   `KTS_ASSERT(a_restart_clears, clock, reset,
      (accept && restart_now) |=> (state_ff == kts_pkg::ST_RESULT
         && var_ff == kts_pkg::VAR_ONE && traj_ff[0] == '0
         && traj_ff[1] == '0 && traj_ff[2] == '0))
   `KTS_ASSERT(a_result_waits, clock, reset,
      (state_ff == kts_pkg::ST_RESULT && rsp_valid_ff && !rsp_chan.ready)
         |=> (state_ff == kts_pkg::ST_RESULT))

endmodule
